// ===== rtl/ogf_pkg.sv =====
`timescale 1ns / 1ps

package ogf_pkg;

    // Global map geometry
    localparam int MAP_COLS  = 128;
    localparam int MAP_ROWS  = 128;
    localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int COL_W     = $clog2(MAP_COLS);
    localparam int ROW_W     = $clog2(MAP_ROWS);

    // Fixed-point datapath, units of 2^-15 cell
    localparam int FRAC_BITS = 15;
    localparam int HALF_W    = 9;   // 2*idx - size, half cells
    localparam int PROD_W    = 25;  // 9 x 16 signed
    localparam int SUM_W     = 27;
    localparam int CELL_W    = 13;  // floor(sum) + size/2

    // Stream words
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COS_HEADING  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_HEADING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X_CELLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y_CELLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_HEIGHT = 3'd5;

    localparam logic signed [15:0] COS_RESET = 16'sd16384;
    localparam logic signed [15:0] SIN_RESET = 16'sd0;
    localparam logic signed [15:0] POS_RESET = 16'sd0;
    localparam logic [7:0]         SIZE_RESET = 8'd100;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SUM,
        ST_READ,
        ST_UPD
    } state_t;

    // Resolved target of one item
    typedef struct packed {
        logic                    fuse;
        logic                    in_bounds;
        logic [6:0]              x;
        logic [6:0]              y;
        logic [ADDR_W-1:0]       addr;
        logic signed [7:0]       cost;
    } target_t;

    // Map write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } map_wr_t;

endpackage

// ===== rtl/ogf_map_ram.sv =====
`timescale 1ns / 1ps

module ogf_map_ram
    import ogf_pkg::*;
(
    input  logic              aclk,
    input  map_wr_t           wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [MAP_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ogf_xform.sv =====
`timescale 1ns / 1ps

module ogf_xform
    import ogf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // config
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // item fields, sampled on load
    input  logic                  load,
    input  logic                  action,
    input  logic [6:0]            local_row,
    input  logic [6:0]            local_col,
    input  logic signed [7:0]     cell_cost,
    input  logic [6:0]            read_x,
    input  logic [6:0]            read_y,
    // second stage
    input  logic                  sum_en,
    output target_t               tgt
);

    logic signed [15:0] cos_reg, sin_reg, pos_x_reg, pos_y_reg;
    logic [7:0]         lwidth_reg, lheight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg     <= COS_RESET;
            sin_reg     <= SIN_RESET;
            pos_x_reg   <= POS_RESET;
            pos_y_reg   <= POS_RESET;
            lwidth_reg  <= SIZE_RESET;
            lheight_reg <= SIZE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_COS_HEADING:  cos_reg     <= cfg_wdata;
                REG_SIN_HEADING:  sin_reg     <= cfg_wdata;
                REG_POS_X_CELLS:  pos_x_reg   <= cfg_wdata;
                REG_POS_Y_CELLS:  pos_y_reg   <= cfg_wdata;
                REG_LOCAL_WIDTH:  lwidth_reg  <= cfg_wdata[7:0];
                REG_LOCAL_HEIGHT: lheight_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Stage 1: centre in half cells, four products
    logic signed [HALF_W-1:0] xh, yh;
    logic signed [PROD_W-1:0] p_xc, p_xs, p_yc, p_ys;

    assign xh = $signed({1'b0, local_row, 1'b0}) - $signed({1'b0, lwidth_reg});
    assign yh = $signed({1'b0, local_col, 1'b0}) - $signed({1'b0, lheight_reg});
    assign p_xc = PROD_W'(xh) * PROD_W'(cos_reg);
    assign p_xs = PROD_W'(xh) * PROD_W'(sin_reg);
    assign p_yc = PROD_W'(yh) * PROD_W'(cos_reg);
    assign p_ys = PROD_W'(yh) * PROD_W'(sin_reg);

    logic signed [PROD_W-1:0] p_xc_reg, p_xs_reg, p_yc_reg, p_ys_reg;
    logic                     action_reg;
    logic [6:0]               read_x_reg, read_y_reg;
    logic signed [7:0]        cost_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            p_xc_reg   <= p_xc;
            p_xs_reg   <= p_xs;
            p_yc_reg   <= p_yc;
            p_ys_reg   <= p_ys;
            action_reg <= action;
            read_x_reg <= read_x;
            read_y_reg <= read_y;
            cost_reg   <= cell_cost;
        end
    end

    // Stage 2: sum, floor, offset, bounds, address
    logic signed [SUM_W-1:0]  gx, gy;
    logic signed [CELL_W-1:0] col, row;
    logic                     fuse_ok, read_ok;
    logic [ADDR_W-1:0]        fuse_addr, read_addr;
    target_t                  tgt_next, tgt_reg;

    assign gx = {{2{p_xc_reg[PROD_W-1]}}, p_xc_reg} - {{2{p_ys_reg[PROD_W-1]}}, p_ys_reg}
              + {{4{pos_x_reg[15]}}, pos_x_reg, 7'b0};
    assign gy = {{2{p_xs_reg[PROD_W-1]}}, p_xs_reg} + {{2{p_yc_reg[PROD_W-1]}}, p_yc_reg}
              + {{4{pos_y_reg[15]}}, pos_y_reg, 7'b0};

    // dropping the fraction bits of a two's complement value is a floor
    assign col = {gx[SUM_W-1], gx[SUM_W-1:FRAC_BITS]} + CELL_W'(MAP_COLS / 2);
    assign row = {gy[SUM_W-1], gy[SUM_W-1:FRAC_BITS]} + CELL_W'(MAP_ROWS / 2);

    assign fuse_ok = !col[CELL_W-1] && (col < CELL_W'(MAP_COLS))
                  && !row[CELL_W-1] && (row < CELL_W'(MAP_ROWS));
    assign read_ok = ({25'd0, read_x_reg} < 32'(MAP_COLS))
                  && ({25'd0, read_y_reg} < 32'(MAP_ROWS));

    assign fuse_addr = ADDR_W'(row[ROW_W-1:0]) * ADDR_W'(MAP_COLS)
                     + ADDR_W'(col[COL_W-1:0]);
    assign read_addr = ADDR_W'(ROW_W'(read_y_reg)) * ADDR_W'(MAP_COLS)
                     + ADDR_W'(COL_W'(read_x_reg));

    always_comb begin
        tgt_next.fuse = !action_reg;
        tgt_next.cost = cost_reg;
        if (!action_reg) begin
            tgt_next.in_bounds = fuse_ok;
            tgt_next.x         = col[6:0];
            tgt_next.y         = row[6:0];
            tgt_next.addr      = fuse_addr;
        end else begin
            tgt_next.in_bounds = read_ok;
            tgt_next.x         = read_x_reg;
            tgt_next.y         = read_y_reg;
            tgt_next.addr      = read_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_en) begin
            tgt_reg <= tgt_next;
        end
    end

    assign tgt = tgt_reg;

endmodule

// ===== rtl/occupancy_grid_rotate_max_fusion_core.sv =====
`timescale 1ns / 1ps
// A taken word passes the stage-1 product registers, the target register and the map read
// register, then update loads the output register, waiting while it holds an untaken result.
// Each item is a map memory read-modify-write (centre/multiply, sum/bounds, read, update),
// with no overlap between items. A finished result waits in the output register while the
// next item is taken. Reset (aresetn low, synchronous): config registers return to defaults,
// then a clearing pass zeroes all 16384 map cells, one per cycle, holding s_tready low.
module occupancy_grid_rotate_max_fusion_core
    import ogf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // config write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // action[0], local_row[7:1], local_col[14:8], cell_cost[22:15],
    // read_x[29:23], read_y[36:30], zero fill above
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // in_bounds[0], target_x[7:1], target_y[14:8], stored_cost[22:15], zero fill above
    output logic [M_TDATA_W-1:0]  m_tdata
);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_last;
    logic              accept, sum_en, rd_en, upd_go, clr_we;
    target_t           tgt;
    map_wr_t           map_wr;
    logic [7:0]        rd_data;
    logic signed [7:0] old_cost, new_cost, res_cost;

    assign accept   = s_tvalid && s_tready;
    assign clr_last = (clr_cnt_reg == ADDR_W'(MAP_DEPTH - 1));

    ogf_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .load      (accept),
        .action    (s_tdata[0]),
        .local_row (s_tdata[7:1]),
        .local_col (s_tdata[14:8]),
        .cell_cost (s_tdata[22:15]),
        .read_x    (s_tdata[29:23]),
        .read_y    (s_tdata[36:30]),
        .sum_en    (sum_en),
        .tgt       (tgt)
    );

    ogf_map_ram u_map (
        .aclk    (aclk),
        .wr      (map_wr),
        .rd_en   (rd_en),
        .rd_addr (tgt.addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_last) state_next = ST_IDLE;
            ST_IDLE:  if (accept)   state_next = ST_SUM;
            ST_SUM:   state_next = ST_READ;
            ST_READ:  state_next = ST_UPD;
            ST_UPD:   if (upd_go)   state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        sum_en   = 1'b0;
        rd_en    = 1'b0;
        upd_go   = 1'b0;
        clr_we   = 1'b0;
        case (state_reg)
            ST_CLEAR: clr_we   = 1'b1;
            ST_IDLE:  s_tready = 1'b1;
            ST_SUM:   sum_en   = 1'b1;
            ST_READ:  rd_en    = 1'b1;
            ST_UPD:   upd_go   = !m_tvalid || m_tready;
            default: ;
        endcase
    end

    assign clr_cnt_next = clr_we ? clr_cnt_reg + ADDR_W'(1) : clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // max fusion
    assign old_cost = rd_data;
    assign new_cost = (tgt.cost > old_cost) ? tgt.cost : old_cost;
    assign res_cost = tgt.fuse ? new_cost : old_cost;

    always_comb begin
        map_wr.en   = clr_we || (upd_go && tgt.fuse && tgt.in_bounds);
        map_wr.addr = clr_we ? clr_cnt_reg : tgt.addr;
        map_wr.data = clr_we ? 8'd0 : new_cost;
    end

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_inb_reg;
    logic [6:0]        out_x_reg, out_y_reg;
    logic [7:0]        out_cost_reg;

    assign out_valid_next = upd_go ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd_go) begin
            out_inb_reg  <= tgt.in_bounds;
            out_x_reg    <= tgt.in_bounds ? tgt.x : 7'd0;
            out_y_reg    <= tgt.in_bounds ? tgt.y : 7'd0;
            out_cost_reg <= tgt.in_bounds ? res_cost : 8'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_cost_reg, out_y_reg, out_x_reg, out_inb_reg};

    // checks
    a_accept_to_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_SUM)
        else $error("accepted word did not start the transform");

    a_no_write_out_of_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD && !tgt.in_bounds) |-> !map_wr.en)
        else $error("map written for an out-of-range cell");

    a_fuse_keeps_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_go && tgt.fuse && tgt.in_bounds) |->
            ($signed(map_wr.data) >= tgt.cost && $signed(map_wr.data) >= old_cost))
        else $error("fused cost below an input cost");

    a_valid_from_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_UPD))
        else $error("result raised outside update");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!s_tready && !m_tvalid))
        else $error("stream activity during map clear");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ogf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic ACT_FUSE       = 1'b0;
    localparam logic ACT_READ       = 1'b1;
    localparam int   WATCHDOG_LIMIT = 60000;  // covers the map clearing pass after reset
    localparam int   LONG_HOLD      = 300;
    localparam int   SETTLE         = 8;

    // same bit order as m_tdata: in_bounds in bit 0
    typedef struct packed {
        logic signed [7:0] cost;
        logic [6:0]        y;
        logic [6:0]        x;
        logic              in_bounds;
    } cell_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;

    occupancy_grid_rotate_max_fusion_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // mirror of the global map and of the registers
    logic signed [7:0]  grid_cost [MAP_DEPTH];
    logic signed [15:0] hd_cos, hd_sin, robot_x, robot_y;
    logic [7:0]         span_w, span_h;

    cell_result_t         predicted_cells [$];
    logic [S_TDATA_W-1:0] word_queue [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int stall_cycles   = 0;
    int mismatches     = 0;
    int n_fused        = 0;
    int n_dropped      = 0;
    int n_reads        = 0;
    int n_settings     = 1;
    logic [6:0] last_row = 7'd0;
    logic [6:0] last_col = 7'd0;

    // local cell -> global column/row, exact in units of 2^-15 cell
    function automatic void locate(input logic [6:0] row, input logic [6:0] col,
                                   output longint cell_x, output longint cell_y);
        longint xh, yh, gx, gy;
        xh = 2 * longint'(row) - longint'(span_w);
        yh = 2 * longint'(col) - longint'(span_h);
        gx = xh * longint'(hd_cos) - yh * longint'(hd_sin) + longint'(robot_x) * 128;
        gy = xh * longint'(hd_sin) + yh * longint'(hd_cos) + longint'(robot_y) * 128;
        cell_x = (gx >>> FRAC_BITS) + MAP_COLS / 2;
        cell_y = (gy >>> FRAC_BITS) + MAP_ROWS / 2;
    endfunction

    function automatic cell_result_t fuse_or_read(input logic [S_TDATA_W-1:0] w);
        cell_result_t      r;
        longint            cx, cy;
        logic signed [7:0] cost;
        int                idx;
        r = '0;
        if (w[0] == ACT_FUSE) begin
            locate(w[7:1], w[14:8], cx, cy);
            cost = w[22:15];
            if (cx >= 0 && cx < MAP_COLS && cy >= 0 && cy < MAP_ROWS) begin
                idx = int'(cy) * MAP_COLS + int'(cx);
                if (cost > grid_cost[idx])
                    grid_cost[idx] = cost;
                r.in_bounds = 1'b1;
                r.x         = cx[6:0];
                r.y         = cy[6:0];
                r.cost      = grid_cost[idx];
            end
        end else begin
            r.in_bounds = 1'b1;
            r.x         = w[29:23];
            r.y         = w[36:30];
            r.cost      = grid_cost[int'(w[36:30]) * MAP_COLS + int'(w[29:23])];
        end
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_word(logic act, logic [6:0] row,
                                                       logic [6:0] col, logic [7:0] cost,
                                                       logic [6:0] rx, logic [6:0] ry);
        return {3'b000, ry, rx, cost, col, row, act};
    endfunction

    always @(posedge aclk) begin : driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= word_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // checks results, then updates the map mirror with the word taken at this edge
    always @(posedge aclk) begin : monitor
        cell_result_t got, want;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            for (int k = 0; k < MAP_DEPTH; k++)
                grid_cost[k] = '0;
            hd_cos  = COS_RESET;
            hd_sin  = SIN_RESET;
            robot_x = POS_RESET;
            robot_y = POS_RESET;
            span_w  = SIZE_RESET;
            span_h  = SIZE_RESET;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[22:0];
                if (predicted_cells.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: in_bounds=%0d x=%0d y=%0d cost=%0d",
                                 got.in_bounds, got.x, got.y, got.cost);
                end else begin
                    want = predicted_cells.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected in_bounds=%0d x=%0d y=%0d cost=%0d,",
                                      " got in_bounds=%0d x=%0d y=%0d cost=%0d"},
                                     want.in_bounds, want.x, want.y, want.cost,
                                     got.in_bounds, got.x, got.y, got.cost);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = fuse_or_read(s_tdata);
                predicted_cells.push_back(want);
                if (s_tdata[0] == ACT_READ)
                    n_reads++;
                else if (want.in_bounds)
                    n_fused++;
                else
                    n_dropped++;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_COS_HEADING:  hd_cos  = cfg_wdata;
                    REG_SIN_HEADING:  hd_sin  = cfg_wdata;
                    REG_POS_X_CELLS:  robot_x = cfg_wdata;
                    REG_POS_Y_CELLS:  robot_y = cfg_wdata;
                    REG_LOCAL_WIDTH:  span_w  = cfg_wdata[7:0];
                    REG_LOCAL_HEIGHT: span_h  = cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (hold_seen != hold_seq) begin
                hold_seen <= hold_seq;
                hold_left <= LONG_HOLD;
                m_tready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic wait_idle();
        do
            @(negedge aclk);
        while (word_queue.size() != 0 || s_tvalid || predicted_cells.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
    endtask

    task automatic cfg_close();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        n_settings++;
    endtask

    task automatic cfg_random();
        cfg_write(REG_COS_HEADING, 16'($urandom_range(32768) - 16384));
        cfg_write(REG_SIN_HEADING, 16'($urandom_range(32768) - 16384));
        cfg_write(REG_POS_X_CELLS, 16'($urandom_range(32768) - 16384));
        cfg_write(REG_POS_Y_CELLS, 16'($urandom_range(32768) - 16384));
        cfg_write(REG_LOCAL_WIDTH, 16'($urandom_range(128, 1)));
        cfg_write(REG_LOCAL_HEIGHT, 16'($urandom_range(128, 1)));
        cfg_close();
    endtask

    task automatic queue_random(int count, int read_pct);
        logic [6:0] row, col, rx, ry;
        logic [7:0] cost;
        longint     cx, cy;
        for (int i = 0; i < count; i++) begin
            row  = $urandom_range(127);
            col  = $urandom_range(127);
            cost = $urandom;
            rx   = $urandom_range(127);
            ry   = $urandom_range(127);
            if ($urandom_range(99) < read_pct) begin
                // half the reads look at the cell fused last
                locate(last_row, last_col, cx, cy);
                if ($urandom_range(1) == 1 && cx >= 0 && cx < MAP_COLS &&
                    cy >= 0 && cy < MAP_ROWS) begin
                    rx = cx[6:0];
                    ry = cy[6:0];
                end
                word_queue.push_back(pack_word(ACT_READ, row, col, cost, rx, ry));
            end else begin
                case ($urandom_range(9))
                    0, 1: begin
                        // same local cell again so max-fusion sees collisions
                        row = last_row;
                        col = last_col;
                    end
                    2, 3, 4, 5, 6: begin
                        row = $urandom_range(span_w > 8'd127 ? 127 : span_w);
                        col = $urandom_range(span_h > 8'd127 ? 127 : span_h);
                    end
                    default: ;
                endcase
                last_row = row;
                last_col = col;
                word_queue.push_back(pack_word(ACT_FUSE, row, col, cost, rx, ry));
            end
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: column = local_row + 14, row = local_col + 14
        word_queue.push_back(pack_word(ACT_READ, 7'd0, 7'd0, 8'h00, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_READ, 7'd127, 7'd127, 8'hFF, 7'd127, 7'd127));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd50, 7'd50, 8'h7F, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd50, 7'd50, 8'h80, 7'd127, 7'd127));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd0, 7'd0, 8'h80, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd1, 7'd1, 8'hFF, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd2, 7'd2, 8'h01, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd127, 7'd0, 8'h7F, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd0, 7'd127, 8'h7F, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd113, 7'd113, 8'h05, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd114, 7'd113, 8'h06, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_FUSE, 7'd113, 7'd114, 8'h06, 7'd0, 7'd0));
        word_queue.push_back(pack_word(ACT_READ, 7'd0, 7'd0, 8'h00, 7'd64, 7'd64));
        word_queue.push_back(pack_word(ACT_READ, 7'd0, 7'd0, 8'h00, 7'd127, 7'd127));
        word_queue.push_back(pack_word(ACT_READ, 7'd0, 7'd0, 8'h00, 7'd14, 7'd14));
        word_queue.push_back(pack_word(ACT_READ, 7'd0, 7'd0, 8'h00, 7'd16, 7'd16));
        wait_idle();

        // quarter turn, full-size local map, no idling
        cfg_write(REG_COS_HEADING, 16'sd0);
        cfg_write(REG_SIN_HEADING, 16'sd16384);
        cfg_write(REG_POS_X_CELLS, 16'sd2560);
        cfg_write(REG_POS_Y_CELLS, -16'sd1203);
        cfg_write(REG_LOCAL_WIDTH, 16'd128);
        cfg_write(REG_LOCAL_HEIGHT, 16'd128);
        cfg_close();
        queue_random(130, 30);
        wait_idle();

        // extreme position and size: almost everything falls off the map
        cfg_write(REG_COS_HEADING, -16'sd16384);
        cfg_write(REG_SIN_HEADING, 16'sd0);
        cfg_write(REG_POS_X_CELLS, 16'h8000);
        cfg_write(REG_POS_Y_CELLS, 16'h7FFF);
        cfg_write(REG_LOCAL_WIDTH, 16'd1);
        cfg_write(REG_LOCAL_HEIGHT, 16'd1);
        cfg_close();
        src_idle_pct = 72;
        queue_random(40, 30);
        wait_idle();

        // 45 degrees, upper bits of the size write must be dropped
        cfg_write(REG_COS_HEADING, 16'sd11585);
        cfg_write(REG_SIN_HEADING, -16'sd11585);
        cfg_write(REG_POS_X_CELLS, 16'sd300);
        cfg_write(REG_POS_Y_CELLS, -16'sd4000);
        cfg_write(REG_LOCAL_WIDTH, 16'hFF40);
        cfg_write(REG_LOCAL_HEIGHT, 16'd32);
        cfg_close();
        src_idle_pct   = 0;
        sink_stall_pct = 72;
        queue_random(130, 30);
        wait_idle();

        // sizes outside the documented range, write to an unmapped index
        cfg_write(REG_SIN_HEADING, -16'sd16384);
        cfg_write(REG_COS_HEADING, 16'sd16384);
        cfg_write(REG_POS_X_CELLS, 16'sd0);
        cfg_write(REG_POS_Y_CELLS, 16'sd0);
        cfg_write(REG_LOCAL_WIDTH, 16'd0);
        cfg_write(REG_LOCAL_HEIGHT, 16'd255);
        cfg_write(REG_UNMAPPED, 16'h1234);
        cfg_close();
        src_idle_pct   = 38;
        sink_stall_pct = 38;
        queue_random(130, 30);
        wait_idle();

        // random pose; receiver holds off while the sender keeps pushing
        cfg_random();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        queue_random(150, 30);
        hold_seq++;
        wait_idle();

        cfg_random();
        src_idle_pct   = 38;
        sink_stall_pct = 38;
        queue_random(120, 40);
        wait_idle();

        $display("fused %0d cells onto the map, dropped %0d off it, read %0d cells",
                 n_fused, n_dropped, n_reads);
        $display("over %0d register settings, %0d mismatches", n_settings, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
